>>> hdl/csfi_pkg.sv
`default_nettype none
package csfi_pkg;

    localparam int NUM_AX = 6;
    localparam logic [24:0] DEG2RAD_Q30 = 25'd18740330;
    localparam logic [14:0] MACH_LIMIT = 15'd13107;
    localparam logic [18:0] COEF_POS_MAX = 19'd262143;
    localparam logic [18:0] COEF_NEG_MAX = 19'd262144;
    localparam logic [40:0] DIM_POS_MAX = 41'h0FFFFFFFFFF;
    localparam logic [40:0] DIM_NEG_MAX = 41'h10000000000;

    localparam logic [15:0] WING_AREA_RST = 16'd31898;
    localparam logic [15:0] MEAN_CHORD_RST = 16'd998;
    localparam logic [15:0] WING_SPAN_RST = 16'd8781;

    localparam logic [1:0] REG_AREA = 2'd0;
    localparam logic [1:0] REG_CHORD = 2'd1;
    localparam logic [1:0] REG_SPAN = 2'd2;

    typedef logic [16:0] dmag_t;
    typedef dmag_t [NUM_AX-1:0] dmag_vec_t;
    typedef logic [NUM_AX-1:0] dsign_t;

    function automatic void deriv_lookup(input logic [2:0] s, output dmag_vec_t m,
                                         output dsign_t n);
        begin
            m = '0;
            n = '0;
            unique case (s)
                3'd0:
                begin
                    m[0] = 17'd328; m[3] = 17'd11665; n[3] = 1'b1;
                    m[4] = 17'd1311; m[5] = 17'd655;
                end
                3'd1:
                begin
                    m[0] = 17'd655; m[2] = 17'd3277; m[3] = 17'd655;
                    m[4] = 17'd73531; n[4] = 1'b1;
                end
                3'd2:
                begin
                    m[0] = 17'd328; m[1] = 17'd5243; m[5] = 17'd4286; n[5] = 1'b1;
                end
                3'd3:
                begin
                    m[0] = 17'd1311; m[2] = 17'd1966; n[2] = 1'b1;
                    m[3] = 17'd3277; n[3] = 1'b1; m[4] = 17'd655;
                end
                3'd4:
                begin
                    m[0] = 17'd1311; m[2] = 17'd9830; m[4] = 17'd3277; n[4] = 1'b1;
                end
                default:
                begin
                    m = '0;
                end
            endcase
        end
    endfunction

endpackage
`default_nettype wire

>>> hdl/control_surface_force_increment.sv
`default_nettype none
// Throughput: one item per cycle.
// The front delay line is matched to the reciprocal and square root pipeline of the Mach factor.
// busy is always low; results appear on done for one cycle, no stall.
// rst_n (async, active low) clears valid bits and restores geometry registers.
module control_surface_force_increment
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [2:0]  surface,
    input  wire logic signed [15:0] deflection_deg,
    input  wire logic        [14:0] mach,
    input  wire logic        [17:0] dyn_pressure,
    output logic                    done,
    output logic signed [18:0]      coef_x,
    output logic signed [18:0]      coef_y,
    output logic signed [18:0]      coef_z,
    output logic signed [18:0]      coef_roll,
    output logic signed [18:0]      coef_pitch,
    output logic signed [18:0]      coef_yaw,
    output logic signed [40:0]      force_x,
    output logic signed [40:0]      force_y,
    output logic signed [40:0]      force_z,
    output logic signed [40:0]      moment_roll,
    output logic signed [40:0]      moment_pitch,
    output logic signed [40:0]      moment_yaw,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic        [3:0]  paddr,
    input  wire logic        [31:0] pwdata,
    output logic             [31:0] prdata,
    output logic                    pready
);
    localparam int FLAT = 20;
    localparam int ALAT = 7;

    logic [15:0] area_reg;
    logic [15:0] chord_reg;
    logic [15:0] span_reg;
    logic        wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_reg  <= csfi_pkg::WING_AREA_RST;
            chord_reg <= csfi_pkg::MEAN_CHORD_RST;
            span_reg  <= csfi_pkg::WING_SPAN_RST;
        end
        else if (wr)
        begin
            if (paddr[3:2] == csfi_pkg::REG_AREA)
            begin
                area_reg <= pwdata[15:0];
            end
            if (paddr[3:2] == csfi_pkg::REG_CHORD)
            begin
                chord_reg <= pwdata[15:0];
            end
            if (paddr[3:2] == csfi_pkg::REG_SPAN)
            begin
                span_reg <= pwdata[15:0];
            end
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            csfi_pkg::REG_AREA:  prdata = {16'd0, area_reg};
            csfi_pkg::REG_CHORD: prdata = {16'd0, chord_reg};
            csfi_pkg::REG_SPAN:  prdata = {16'd0, span_reg};
            default:             prdata = '0;
        endcase
    end

    // front stage
    logic [15:0] dabs;
    logic [16:0] factor;
    assign dabs = deflection_deg[15] ? 16'(-deflection_deg) : deflection_deg;

    csfi_factor u_factor
    (
        .clk    (clk),
        .mach   (mach),
        .factor (factor)
    );

    logic [40:0] rp_reg;
    logic [33:0] qsp_reg;
    logic [2:0]  sf_reg [FLAT+1];
    logic        dn_reg [FLAT+1];
    logic [25:0] rd_reg [FLAT+1];
    logic [33:0] qs_reg [FLAT+1];
    logic [FLAT:0] vl_reg;

    always_ff @(posedge clk)
    begin
        rp_reg  <= 41'(dabs) * 41'(csfi_pkg::DEG2RAD_Q30);
        qsp_reg <= 34'(dyn_pressure) * 34'(area_reg);
        sf_reg[0] <= surface;
        dn_reg[0] <= deflection_deg[15];
        rd_reg[1] <= 26'((rp_reg + 41'h2000) >> 14);
        qs_reg[1] <= qsp_reg;
        sf_reg[1] <= sf_reg[0];
        dn_reg[1] <= dn_reg[0];
        for (int i = 2; i <= FLAT; i++)
        begin
            rd_reg[i] <= rd_reg[i-1];
            qs_reg[i] <= qs_reg[i-1];
            sf_reg[i] <= sf_reg[i-1];
            dn_reg[i] <= dn_reg[i-1];
        end
    end

    logic [ALAT-1:0] va_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vl_reg <= '0;
            va_reg <= '0;
        end
        else
        begin
            vl_reg <= {vl_reg[FLAT-1:0], start};
            va_reg <= {va_reg[ALAT-2:0], vl_reg[FLAT]};
        end
    end

    csfi_pkg::dmag_vec_t dm;
    csfi_pkg::dsign_t    dsn;
    always_comb
    begin
        csfi_pkg::deriv_lookup(sf_reg[FLAT], dm, dsn);
    end

    logic [18:0] cf [6];
    logic [40:0] dd [6];
    logic [15:0] ln [6];
    assign ln[0] = '0;
    assign ln[1] = '0;
    assign ln[2] = '0;
    assign ln[3] = span_reg;
    assign ln[4] = chord_reg;
    assign ln[5] = span_reg;

    genvar a;
    generate
        for (a = 0; a < csfi_pkg::NUM_AX; a++)
        begin : g_ax
            csfi_axis u_axis
            (
                .clk       (clk),
                .dmag      (dm[a]),
                .neg       (dsn[a] ^ dn_reg[FLAT]),
                .rad       (rd_reg[FLAT]),
                .factor    (factor),
                .qs        (qs_reg[FLAT]),
                .len       (ln[a]),
                .is_moment (a >= 3),
                .coef      (cf[a]),
                .dim       (dd[a])
            );
        end
    endgenerate

    assign done         = va_reg[ALAT-1];
    assign coef_x       = cf[0];
    assign coef_y       = cf[1];
    assign coef_z       = cf[2];
    assign coef_roll    = cf[3];
    assign coef_pitch   = cf[4];
    assign coef_yaw     = cf[5];
    assign force_x      = dd[0];
    assign force_y      = dd[1];
    assign force_z      = dd[2];
    assign moment_roll  = dd[3];
    assign moment_pitch = dd[4];
    assign moment_yaw   = dd[5];

`ifndef SYNTHESIS
    a_busy_low: assert property (@(posedge clk) busy == 1'b0)
        else $error("busy asserted");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(va_reg[ALAT-2]))
        else $error("done tracking");
    a_zero_surface: assert property (@(posedge clk) disable iff (!rst_n)
        (done && coef_x == '0 && coef_z == '0 && coef_y == '0) |-> force_x == '0)
        else $error("zero coef gave force");
`endif

endmodule
`default_nettype wire

>>> hdl/csfi_factor.sv
`default_nettype none
// Pipelined Prandtl-Glauert factor: square stage, divisor stage, restoring division
// (34 quotient bits, 4 per stage), then integer square root (2 bits per stage).
module csfi_factor
(
    input  wire logic        clk,
    input  wire logic [14:0] mach,
    output logic      [16:0] factor
);
    // d = 2^28 - m^2, d in [2^28-13107^2 .. 2^28]; quotient 2^60/d < 2^34
    localparam int QB = 34;
    localparam int DSTG = 9;
    localparam int SSTG = 9;

    logic [29:0] m2_reg;
    logic        big_reg;

    always_ff @(posedge clk)
    begin
        m2_reg  <= 30'(mach) * 30'(mach);
        big_reg <= (mach > csfi_pkg::MACH_LIMIT);
    end

    // division: remainder < d <= 2^28 (29 bits)
    logic [28:0] dv_reg  [DSTG+1];
    logic [28:0] rm_reg  [DSTG+1];
    logic [QB-1:0] qt_reg [DSTG+1];
    logic        bg_reg  [DSTG+1];

    always_ff @(posedge clk)
    begin
        dv_reg[0] <= 29'(30'h1000_0000 - m2_reg);
        rm_reg[0] <= '0;
        qt_reg[0] <= '0;
        bg_reg[0] <= big_reg;
    end

    // dividend 2^60: bit 60 only; 61 quotient bit positions, top 27 are zero.
    // Start at bit position QB-1 with remainder seeded by upper dividend bits:
    // 2^60 >> QB = 2^26 < d, so seeding remainder = 2^26 is exact.
    genvar g;
    generate
        for (g = 0; g < DSTG; g++)
        begin : g_div
            always_ff @(posedge clk)
            begin : p
                logic [29:0] r;
                logic [QB-1:0] q;
                r = 30'(rm_reg[g]);
                q = qt_reg[g];
                if (g == 0)
                begin
                    r = 30'h0400_0000;
                end
                for (int k = 0; k < 4; k++)
                begin
                    if (g*4 + k < QB)
                    begin
                        r = {r[28:0], 1'b0};
                        q = {q[QB-2:0], 1'b0};
                        if (r >= 30'(dv_reg[g]))
                        begin
                            r = r - 30'(dv_reg[g]);
                            q[0] = 1'b1;
                        end
                    end
                end
                dv_reg[g+1] <= dv_reg[g];
                rm_reg[g+1] <= r[28:0];
                qt_reg[g+1] <= q;
                bg_reg[g+1] <= bg_reg[g];
            end
        end
    endgenerate

    // sqrt of 34-bit value, 17 result bits, 2 per stage
    logic [QB-1:0] sv_reg [SSTG+1];
    logic [17:0]   sr_reg [SSTG+1];
    logic [16:0]   so_reg [SSTG+1];
    logic          sb_reg [SSTG+1];

    always_ff @(posedge clk)
    begin
        sv_reg[0] <= qt_reg[DSTG];
        sr_reg[0] <= '0;
        so_reg[0] <= '0;
        sb_reg[0] <= bg_reg[DSTG];
    end

    generate
        for (g = 0; g < SSTG; g++)
        begin : g_sqrt
            always_ff @(posedge clk)
            begin : p
                logic [19:0] r;
                logic [16:0] o;
                logic [19:0] t;
                r = 20'(sr_reg[g]);
                o = so_reg[g];
                t = '0;
                for (int k = 0; k < 2; k++)
                begin
                    if (g*2 + k < 17)
                    begin
                        r = {r[17:0], sv_reg[g][QB-1-2*(g*2+k) -: 2]};
                        t = {1'b0, o, 2'b01};
                        o = {o[15:0], 1'b0};
                        if (r >= t)
                        begin
                            r = r - t;
                            o[0] = 1'b1;
                        end
                    end
                end
                sv_reg[g+1] <= sv_reg[g];
                sr_reg[g+1] <= r[17:0];
                so_reg[g+1] <= o;
                sb_reg[g+1] <= sb_reg[g];
            end
        end
    endgenerate

    assign factor = sb_reg[SSTG] ? 17'h10000 : so_reg[SSTG];

endmodule
`default_nettype wire

>>> hdl/csfi_axis.sv
`default_nettype none
// One axis: coefficient, saturation, force/moment scaling.
module csfi_axis
(
    input  wire logic        clk,
    input  wire logic [16:0] dmag,
    input  wire logic        neg,
    input  wire logic [25:0] rad,
    input  wire logic [16:0] factor,
    input  wire logic [33:0] qs,
    input  wire logic [15:0] len,
    input  wire logic        is_moment,
    output logic      [18:0] coef,
    output logic      [40:0] dim
);
    logic [41:0] dr_reg;
    logic [16:0] f1_reg;
    logic        n1_reg;
    logic [33:0] qs1_reg;
    logic [15:0] l1_reg;
    logic        m1_reg;

    always_ff @(posedge clk)
    begin
        dr_reg  <= 42'(dmag) * 42'(rad);
        f1_reg  <= factor;
        n1_reg  <= neg;
        qs1_reg <= qs;
        l1_reg  <= len;
        m1_reg  <= is_moment;
    end

    // dr * factor split: low 24 bits and high 18 bits
    logic [40:0] pl_reg;
    logic [34:0] ph_reg;
    logic        n2_reg;
    logic [33:0] qs2_reg;
    logic [15:0] l2_reg;
    logic        m2_reg;

    always_ff @(posedge clk)
    begin
        pl_reg  <= 41'(dr_reg[23:0]) * 41'(f1_reg);
        ph_reg  <= 35'(dr_reg[41:24]) * 35'(f1_reg);
        n2_reg  <= n1_reg;
        qs2_reg <= qs1_reg;
        l2_reg  <= l1_reg;
        m2_reg  <= m1_reg;
    end

    logic [34:0] cm_full;
    logic [18:0] cmag;
    logic        cneg;
    assign cm_full = 35'((({ph_reg, 24'd0} + 59'(pl_reg) + 59'h80_0000_0000) >> 40));
    assign cneg = n2_reg && (cm_full != '0);
    always_comb
    begin
        if (cneg)
        begin
            cmag = (cm_full > 35'(csfi_pkg::COEF_NEG_MAX)) ? csfi_pkg::COEF_NEG_MAX
                                                          : cm_full[18:0];
        end
        else
        begin
            cmag = (cm_full > 35'(csfi_pkg::COEF_POS_MAX)) ? csfi_pkg::COEF_POS_MAX
                                                          : cm_full[18:0];
        end
    end

    logic [18:0] cm3_reg;
    logic        n3_reg;
    logic [33:0] qs3_reg;
    logic [15:0] l3_reg;
    logic        m3_reg;

    always_ff @(posedge clk)
    begin
        cm3_reg <= cmag;
        n3_reg  <= cneg;
        qs3_reg <= qs2_reg;
        l3_reg  <= l2_reg;
        m3_reg  <= m2_reg;
    end

    // p = cmag * qs (53 bits), split qs in halves of 17
    logic [35:0] pa_reg;
    logic [35:0] pb_reg;
    logic [18:0] cm4_reg;
    logic        n4_reg;
    logic [15:0] l4_reg;
    logic        m4_reg;

    always_ff @(posedge clk)
    begin
        pa_reg  <= 36'(cm3_reg) * 36'(qs3_reg[16:0]);
        pb_reg  <= 36'(cm3_reg) * 36'(qs3_reg[33:17]);
        cm4_reg <= cm3_reg;
        n4_reg  <= n3_reg;
        l4_reg  <= l3_reg;
        m4_reg  <= m3_reg;
    end

    logic [52:0] p5_reg;
    logic        n5_reg;
    logic [15:0] l5_reg;
    logic        m5_reg;
    logic [18:0] cm5_reg;

    always_ff @(posedge clk)
    begin
        p5_reg  <= 53'({pb_reg, 17'd0}) + 53'(pa_reg);
        n5_reg  <= n4_reg;
        l5_reg  <= l4_reg;
        m5_reg  <= m4_reg;
        cm5_reg <= cm4_reg;
    end

    // p*len: (p>>16)*len and (p&0xffff)*len
    logic [52:0] la_reg;
    logic [31:0] lb_reg;
    logic [52:0] p6_reg;
    logic        n6_reg;
    logic        m6_reg;
    logic [18:0] cm6_reg;

    always_ff @(posedge clk)
    begin
        la_reg  <= 53'(p5_reg[52:16]) * 53'(l5_reg);
        lb_reg  <= 32'(p5_reg[15:0]) * 32'(l5_reg);
        p6_reg  <= p5_reg;
        n6_reg  <= n5_reg;
        m6_reg  <= m5_reg;
        cm6_reg <= cm5_reg;
    end

    logic [53:0] msum;
    logic [53:0] fsum;
    logic [40:0] dmg;
    logic [37:0] dfull;
    logic        dneg;
    assign msum  = (54'(la_reg) + 54'(lb_reg[31:16]) + 54'h8000) >> 16;
    assign fsum  = (54'(p6_reg) + 54'h80_0000) >> 24;
    assign dfull = m6_reg ? msum[37:0] : fsum[37:0];
    assign dneg  = n6_reg && (dfull != '0);
    assign dmg   = 41'(dfull);

    always_ff @(posedge clk)
    begin
        coef <= n6_reg ? 19'(~cm6_reg + 19'd1) : cm6_reg;
        dim  <= dneg ? (~dmg + 41'd1) : dmg;
    end

endmodule
`default_nettype wire

>>> dv/control_surface_force_increment_test.sv
`timescale 1ns / 100ps
module control_surface_force_increment_test;

    typedef struct {
        logic signed [18:0] coef [6];
        logic signed [40:0] dim [6];
    } increment_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [2:0] surface = '0;
    logic signed [15:0] deflection_deg = '0;
    logic [14:0] mach = '0;
    logic [17:0] dyn_pressure = '0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic busy;
    logic done;
    logic [31:0] prdata;
    logic pready;
    logic signed [18:0] coef_x, coef_y, coef_z, coef_roll, coef_pitch, coef_yaw;
    logic signed [40:0] force_x, force_y, force_z, moment_roll, moment_pitch, moment_yaw;

    increment_t expected_q[$];
    int errors = 0;
    int quiet_cycles = 0;
    longint unsigned area_r = csfi_pkg::WING_AREA_RST;
    longint unsigned chord_r = csfi_pkg::MEAN_CHORD_RST;
    longint unsigned span_r = csfi_pkg::WING_SPAN_RST;

    // Q16 derivatives: axial, side, normal, roll, pitch, yaw
    int surf_deriv [8][6] = '{
        '{328, 0, 0, -11665, 1311, 655},
        '{655, 0, 3277, 655, -73531, 0},
        '{328, 5243, 0, 0, 0, -4286},
        '{1311, 0, -1966, -3277, 655, 0},
        '{1311, 0, 9830, 0, -3277, 0},
        '{0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0}
    };

    control_surface_force_increment dut (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 20; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic increment_t predict_increment(logic [2:0] s, logic [15:0] d,
                                                     logic [14:0] m, logic [17:0] q);
        increment_t res;
        logic dneg;
        longint unsigned dmag, rad, pg, qs, dm, cmag, p, dim, hi, lo;
        logic neg;
        dneg = d[15];
        dmag = dneg ? (64'h10000 - d) : d;
        rad = (dmag * 64'd18740330 + 64'd8192) >> 14;
        pg = 65536;
        if (m <= 15'd13107)
            pg = sqrt_floor((64'd1 << 60) / ((64'd1 << 28) - m * m));
        qs = q * area_r;
        for (int k = 0; k < 6; k++)
        begin
            dm = surf_deriv[s][k] < 0 ? -surf_deriv[s][k] : surf_deriv[s][k];
            neg = (surf_deriv[s][k] < 0) != dneg;
            cmag = (dm * rad * pg + (64'd1 << 39)) >> 40;
            if (cmag == 0)
                neg = 1'b0;
            if (neg && cmag > 262144)
                cmag = 262144;
            if (!neg && cmag > 262143)
                cmag = 262143;
            res.coef[k] = neg ? -cmag[18:0] : cmag[18:0];
            p = cmag * qs;
            if (k < 3)
                dim = (p + (64'd1 << 23)) >> 24;
            else
            begin
                hi = (p >> 16) * (k == 4 ? chord_r : span_r);
                lo = (p & 64'hFFFF) * (k == 4 ? chord_r : span_r);
                dim = (hi + (lo >> 16) + 64'h8000) >> 16;
            end
            if (dim == 0)
                neg = 1'b0;
            if (neg && dim > 64'h10000000000)
                dim = 64'h10000000000;
            if (!neg && dim > 64'hFFFFFFFFFF)
                dim = 64'hFFFFFFFFFF;
            res.dim[k] = neg ? -dim[40:0] : dim[40:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        increment_t want;
        logic signed [18:0] gc [6];
        logic signed [40:0] gd [6];
        if (done)
        begin
            gc = '{coef_x, coef_y, coef_z, coef_roll, coef_pitch, coef_yaw};
            gd = '{force_x, force_y, force_z, moment_roll, moment_pitch, moment_yaw};
            if (expected_q.size() == 0)
                report_mismatch("unexpected item", 0, 0);
            else
            begin
                want = expected_q.pop_front();
                for (int k = 0; k < 6; k++)
                begin
                    if (gc[k] !== want.coef[k])
                        report_mismatch($sformatf("coef[%0d]", k), gc[k], want.coef[k]);
                    if (gd[k] !== want.dim[k])
                        report_mismatch($sformatf("dim[%0d]", k), gd[k], want.dim[k]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 3000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(logic [2:0] s, logic [15:0] d, logic [14:0] m, logic [17:0] q);
        logic ok;
        start <= 1'b1;
        surface <= s;
        deflection_deg <= d;
        mach <= m;
        dyn_pressure <= q;
        do
        begin
            @(negedge clk);
            ok = !busy;
            @(posedge clk);
        end
        while (!ok);
        expected_q = {expected_q, predict_increment(s, d, m, q)};
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        pause(1);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (35) @(posedge clk);
    endtask

    task automatic write_geometry(logic [1:0] idx, logic [15:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            csfi_pkg::REG_AREA: area_r = v;
            csfi_pkg::REG_CHORD: chord_r = v;
            default: span_r = v;
        endcase
    endtask

    task automatic random_item();
        logic [15:0] d;
        logic [14:0] m;
        d = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 46080) - 23040);
        case ($urandom_range(0, 3))
            0: m = 15'($urandom_range(0, 13107));
            1: m = 15'($urandom_range(13100, 13115));
            default: m = 15'($urandom);
        endcase
        send_item(3'($urandom_range(0, 7)), d, m, 18'($urandom));
    endtask

    task automatic test_directed();
        for (int s = 0; s < 8; s++)
            send_item(3'(s), 16'sd2560, 15'd8192, 18'd20000);
        send_item(3'd1, 16'sd23040, 15'd0, 18'd262143);
        send_item(3'd1, -16'sd23040, 15'd13107, 18'd262143);
        send_item(3'd0, 16'h8000, 15'd13107, 18'd262143);
        send_item(3'd4, 16'h7FFF, 15'd32767, 18'd262143);
        send_item(3'd2, 16'sd0, 15'd13108, 18'd1000);
        send_item(3'd3, -16'sd1, 15'd13106, 18'd0);
        send_item(3'd0, 16'sd1, 15'd16384, 18'd1);
        send_item(3'd4, -16'sd256, 15'd32767, 18'd262143);
        drain();
    endtask

    task automatic test_geometry();
        logic [15:0] vals [4] = '{16'd1, 16'd65535, 16'd0, 16'd12345};
        foreach (vals[i])
        begin
            write_geometry(csfi_pkg::REG_AREA, vals[i]);
            write_geometry(csfi_pkg::REG_CHORD, vals[(i + 1) % 4]);
            write_geometry(csfi_pkg::REG_SPAN, vals[(i + 2) % 4]);
            for (int s = 0; s < 6; s++)
                send_item(3'(s), 16'sd23040, 15'd13107, 18'd262143);
            for (int j = 0; j < 20; j++)
                random_item();
            drain();
        end
    endtask

    task automatic test_random(int n);
        int sent;
        int burst;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst; j++)
                random_item();
            sent += burst;
            if ($urandom_range(0, 2) != 0)
                pause($urandom_range(1, 12));
            if (sent % 300 < burst)
                drain();
        end
        drain();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_geometry();
        write_geometry(csfi_pkg::REG_AREA, csfi_pkg::WING_AREA_RST);
        write_geometry(csfi_pkg::REG_CHORD, csfi_pkg::MEAN_CHORD_RST);
        write_geometry(csfi_pkg::REG_SPAN, csfi_pkg::WING_SPAN_RST);
        test_random(1200);
        if (errors == 0 && expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
